// ----- design/gsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types, constants and the blend arithmetic for the gradient strip
// renderer.
// ----------------------------------------------------------------------------
package gsc_pkg;

  // strip geometry bounds
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 16;
  localparam int ROW_CAP    = 16;
  localparam int H_CAP      = (MAX_HEIGHT < ROW_CAP) ? MAX_HEIGHT : ROW_CAP;

  // field widths
  localparam int COLOR_W = 32;
  localparam int WIDTH_W = 10;
  localparam int HEIGHT_W = 5;
  localparam int GRAY_W  = 8;
  localparam int ROW_W   = 4;
  localparam int ACC_W   = 25;
  localparam int NUM_CH  = 4;

  // step division: 8-bit magnitude shifted up by 16
  localparam int DIV_BITS = 24;
  localparam int DIV_CNT_W = 5;
  localparam int HALF_W   = 9;

  // register reset values
  localparam logic [COLOR_W-1:0]  START_COLOR_RST = 32'h0000_00ff;
  localparam logic [COLOR_W-1:0]  MID_COLOR_RST   = 32'hff00_00ff;
  localparam logic [COLOR_W-1:0]  END_COLOR_RST   = 32'hffff_ffff;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST       = 10'd96;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST      = 5'd8;
  localparam logic [GRAY_W-1:0]   DARK_RST        = 8'h5f;
  localparam logic [GRAY_W-1:0]   LIGHT_RST       = 8'ha0;
  localparam logic [GRAY_W-1:0]   MASK_RST        = 8'h08;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_COLOR  = 3'd0,
    REG_MID_COLOR    = 3'd1,
    REG_END_COLOR    = 3'd2,
    REG_STRIP_WIDTH  = 3'd3,
    REG_STRIP_HEIGHT = 3'd4,
    REG_CHECK_DARK   = 3'd5,
    REG_CHECK_LIGHT  = 3'd6,
    REG_CHECK_MASK   = 3'd7
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_DIVIDE,
    ST_STEP_WRITE,
    ST_EMIT
  } gsc_state_t;

  // controller to datapath
  typedef struct packed {
    logic row_clear;
    logic load_start;
    logic advance;
    logic load_mid;
    logic div_step;
    logic write_step;
    logic emit;
  } gsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic past_end;
    logic switch_due;
    logic div_last;
    logic no_rows;
    logic row_last;
    logic out_free;
  } gsc_status_t;

  // channel i of a packed rgba word, red first
  function automatic logic [7:0] chan_of(input logic [COLOR_W-1:0] rgba,
                                         input int unsigned idx);
    return rgba[31 - 8*idx -: 8];
  endfunction

  // bg + floor((fc + floor(fc/256) + 128) / 256), fc = (color - bg) * alpha
  function automatic logic [7:0] blend(input logic [7:0] color,
                                       input logic [7:0] bg,
                                       input logic [7:0] alpha);
    logic signed [8:0]  diff;
    logic signed [8:0]  alpha_s;
    logic signed [17:0] fc;
    logic signed [18:0] sum;
    logic signed [18:0] shr;
    diff    = $signed({1'b0, color}) - $signed({1'b0, bg});
    alpha_s = $signed({1'b0, alpha});
    fc      = diff * alpha_s;
    sum     = 19'(fc) + 19'(fc >>> 8) + 19'sd128;
    shr     = sum >>> 8;
    return bg + shr[7:0];
  endfunction

endpackage

// ----- design/gsc_in_if.sv -----
// ----------------------------------------------------------------------------
// gsc_in_if
// Column request channel: one request draws one column of the strip.
// ----------------------------------------------------------------------------
interface gsc_in_if;
  logic valid;
  logic ready;
  logic start_strip;

  modport source (output valid, output start_strip, input ready);
  modport sink   (input valid, input start_strip, output ready);
endinterface

// ----- design/gsc_out_if.sv -----
// ----------------------------------------------------------------------------
// gsc_out_if
// Pixel channel: one blended pixel per request.
// ----------------------------------------------------------------------------
interface gsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] pixel_row;
  logic [9:0] pixel_column;
  logic       last_in_column;

  modport source (output valid, output red, output green, output blue,
                  output pixel_row, output pixel_column, output last_in_column,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input pixel_row, input pixel_column, input last_in_column,
                  output ready);
endinterface

// ----- design/gradient_strip_checker_blend.sv -----
// ----------------------------------------------------------------------------
// gradient_strip_checker_blend
// Two-segment RGBA gradient strip blended over a checkerboard, one column
// per request, one pixel per output request.
// ----------------------------------------------------------------------------
// Channels: strip (sink) carries start_strip; a request with start_strip set
// restarts at column 0, otherwise the next column is drawn. pixel (source)
// returns one blended pixel per row, rows in increasing order, with
// last_in_column on the final row. Registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle, a rule for the user that the
// block itself does not enforce. The step division runs four lanes, one
// quotient bit per cycle, to a 24-bit quotient per lane. A restart loads the
// first segment, divides and writes the steps before its first pixel; a
// column entering the second segment advances, reloads and divides first;
// a plain advance goes straight to its rows. Throughput: one pixel per cycle
// from the output register while the receiver is ready. A request past the
// end of the strip gives no pixels. Reset clears the accumulators, steps and
// column position and loads the register defaults. When the receiver stalls,
// the held pixel stays in the output register and the row walk waits.
// ----------------------------------------------------------------------------
module gradient_strip_checker_blend (
  input  logic                        clk,
  input  logic                        rst,
  gsc_in_if.sink                      strip,
  gsc_out_if.source                   pixel,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [gsc_pkg::COLOR_W-1:0] cfg_data
);
  import gsc_pkg::*;

  gsc_cmd_t    cmd;
  gsc_status_t status;

  // sequencer
  gsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (strip.valid),
    .in_start (strip.start_strip),
    .in_ready (strip.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  gsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (pixel.ready),
    .out_valid      (pixel.valid),
    .red            (pixel.red),
    .green          (pixel.green),
    .blue           (pixel.blue),
    .pixel_row      (pixel.pixel_row),
    .pixel_column   (pixel.pixel_column),
    .last_in_column (pixel.last_in_column)
  );

endmodule

// ----- design/gsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gsc_ctrl
// Sequencer: accepts a column request, steps the accumulators or reloads a
// segment, runs the step division and walks the rows of the column.
// ----------------------------------------------------------------------------
module gsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_start,
  output logic                 in_ready,
  input  gsc_pkg::gsc_status_t status,
  output gsc_pkg::gsc_cmd_t    cmd
);
  import gsc_pkg::*;

  gsc_state_t state;
  gsc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.row_clear = 1'b1;
          if (in_start) begin
            cmd.load_start = 1'b1;
            state_next     = ST_DIVIDE;
          end else if (!status.past_end) begin
            cmd.advance = 1'b1;
            state_next  = ST_ADVANCE;
          end
        end
      end
      ST_ADVANCE: begin
        if (status.switch_due) begin
          cmd.load_mid = 1'b1;
          state_next   = ST_DIVIDE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_STEP_WRITE;
        end
      end
      ST_STEP_WRITE: begin
        cmd.write_step = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.no_rows) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.row_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/gsc_datapath.sv -----
// ----------------------------------------------------------------------------
// gsc_datapath
// Configuration registers, 9.16 channel accumulators and steps, a four-lane
// restoring divider, the row counter and the registered pixel output.
// ----------------------------------------------------------------------------
module gsc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [gsc_pkg::COLOR_W-1:0]     cfg_data,
  input  gsc_pkg::gsc_cmd_t               cmd,
  output gsc_pkg::gsc_status_t            status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [gsc_pkg::ROW_W-1:0]       pixel_row,
  output logic [gsc_pkg::WIDTH_W-1:0]     pixel_column,
  output logic                            last_in_column
);
  import gsc_pkg::*;

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HCap = HEIGHT_W'(H_CAP);
  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_BITS - 1);

  // configuration
  logic [COLOR_W-1:0]  start_color;
  logic [COLOR_W-1:0]  mid_color;
  logic [COLOR_W-1:0]  end_color;
  logic [WIDTH_W-1:0]  strip_width;
  logic [HEIGHT_W-1:0] strip_height;
  logic [GRAY_W-1:0]   checker_dark;
  logic [GRAY_W-1:0]   checker_light;
  logic [GRAY_W-1:0]   checker_mask;

  // gradient state
  logic [ACC_W-1:0]    accum [NUM_CH];
  logic [ACC_W-1:0]    step  [NUM_CH];
  logic [WIDTH_W-1:0]  col;
  logic                second;
  logic [ROW_W-1:0]    row;

  // divider lanes
  logic [DIV_BITS-1:0]  dvd     [NUM_CH];
  logic [HALF_W-1:0]    rem     [NUM_CH];
  logic                 neg     [NUM_CH];
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [WIDTH_W-1:0]  w_clip;
  logic [HALF_W-1:0]   half;
  logic [WIDTH_W-1:0]  total;
  logic [HEIGHT_W-1:0] h_clip;
  logic                out_free;
  logic [COLOR_W-1:0]  seg_from;
  logic [COLOR_W-1:0]  seg_to;
  logic [GRAY_W-1:0]   bg;
  logic [WIDTH_W-1:0]  check_bits;

  // geometry after clipping
  always_comb begin
    w_clip = (13'(strip_width) > MaxW) ? MaxW[WIDTH_W-1:0] : strip_width;
    half   = w_clip[WIDTH_W-1:1];
    total  = {half, 1'b0};
    h_clip = (strip_height > HCap) ? HCap : strip_height;
  end

  assign out_free = !out_valid || out_ready;

  // status to controller
  always_comb begin
    status.past_end   = (col >= total);
    status.switch_due = !second && (col >= {1'b0, half});
    status.div_last   = (div_cnt == DivLast);
    status.no_rows    = (col >= total) || (h_clip == '0);
    status.row_last   = ((HEIGHT_W'(row) + 5'd1) == h_clip);
    status.out_free   = out_free;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_color   <= START_COLOR_RST;
      mid_color     <= MID_COLOR_RST;
      end_color     <= END_COLOR_RST;
      strip_width   <= WIDTH_RST;
      strip_height  <= HEIGHT_RST;
      checker_dark  <= DARK_RST;
      checker_light <= LIGHT_RST;
      checker_mask  <= MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COLOR:  start_color   <= cfg_data;
        REG_MID_COLOR:    mid_color     <= cfg_data;
        REG_END_COLOR:    end_color     <= cfg_data;
        REG_STRIP_WIDTH:  strip_width   <= cfg_data[WIDTH_W-1:0];
        REG_STRIP_HEIGHT: strip_height  <= cfg_data[HEIGHT_W-1:0];
        REG_CHECK_DARK:   checker_dark  <= cfg_data[GRAY_W-1:0];
        REG_CHECK_LIGHT:  checker_light <= cfg_data[GRAY_W-1:0];
        REG_CHECK_MASK:   checker_mask  <= cfg_data[GRAY_W-1:0];
        default: ;
      endcase
    end
  end

  // segment endpoints for a reload
  assign seg_from = cmd.load_start ? start_color : mid_color;
  assign seg_to   = cmd.load_start ? mid_color   : end_color;

  // column position and segment flag
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      second <= 1'b0;
    end else if (cmd.load_start) begin
      col    <= '0;
      second <= 1'b0;
    end else if (cmd.advance) begin
      col <= col + 10'd1;
    end else if (cmd.load_mid) begin
      second <= 1'b1;
    end
  end

  // accumulators and steps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        accum[i] <= '0;
        step[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cmd.load_start || cmd.load_mid) begin
          accum[i] <= {1'b0, chan_of(seg_from, i), 16'h0000};
        end else if (cmd.advance) begin
          accum[i] <= accum[i] + step[i];
        end
        if (cmd.write_step) begin
          if (half == '0) begin
            step[i] <= '0;
          end else if (neg[i]) begin
            step[i] <= '0 - {1'b0, dvd[i]};
          end else begin
            step[i] <= {1'b0, dvd[i]};
          end
        end
      end
    end
  end

  // restoring divider, one quotient bit per lane each cycle that div_step is set
  always_ff @(posedge clk) begin
    logic signed [8:0] diff;
    logic [8:0]        mag;
    logic [9:0]        trial;
    logic              ge;
    if (cmd.load_start || cmd.load_mid) begin
      div_cnt <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        diff   = $signed({1'b0, chan_of(seg_to, i)}) - $signed({1'b0, chan_of(seg_from, i)});
        mag    = diff[8] ? 9'(-diff) : 9'(diff);
        neg[i] <= diff[8];
        dvd[i] <= {mag[7:0], 16'h0000};
        rem[i] <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 5'd1;
      for (int i = 0; i < NUM_CH; i++) begin
        trial  = {rem[i], dvd[i][DIV_BITS-1]};
        ge     = (trial >= {1'b0, half});
        rem[i] <= ge ? 9'(trial - {1'b0, half}) : trial[HALF_W-1:0];
        dvd[i] <= {dvd[i][DIV_BITS-2:0], ge};
      end
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (cmd.row_clear) begin
      row <= '0;
    end else if (cmd.emit) begin
      row <= row + 4'd1;
    end
  end

  // checker background of the current pixel
  assign check_bits = (col & {2'b00, checker_mask}) ^ ({6'd0, row} & {2'b00, checker_mask});
  assign bg         = (check_bits != '0) ? checker_dark : checker_light;

  // pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red            <= blend(accum[0][23:16], bg, accum[3][23:16]);
      green          <= blend(accum[1][23:16], bg, accum[3][23:16]);
      blue           <= blend(accum[2][23:16], bg, accum[3][23:16]);
      pixel_row      <= row;
      pixel_column   <= col;
      last_in_column <= status.row_last;
    end
  end

endmodule
